// File: rtl/core/btb1_pkg.sv
// Shared constants and types for the one-bit branch target buffer.
// No dependencies; used by branch_target_buffer_one_bit.
`default_nettype none

package btb1_pkg;

    // Statistics counters
    localparam int unsigned COUNT_W = 32;
    typedef logic [COUNT_W-1:0] t_count;
    localparam t_count COUNT_MAX = '1;

    // Taken-distance register
    localparam int unsigned DIST_W = 16;
    typedef logic [DIST_W-1:0] t_dist;
    localparam t_dist DIST_RESET = 16'd15;

endpackage

`default_nettype wire

// File: rtl/core/branch_target_buffer_one_bit.sv
// One-bit branch target buffer: associative lookup, prediction update and counters.
// Depends on btb1_pkg (counter and distance types, reset constants).
//
// Each transaction carries an executed address and its successor. A branch counts
// as taken when the successor is lower, or higher by more than taken_distance.
// The block takes one transaction per clock while the result side is not stalled;
// a result-side stall holds the input off in the same cycle. An accepted transaction
// passes the input register, then the result register, where its result is valid.
// The lookup, the entry update and the counter update of one transaction all happen
// together as it moves from the input register into the result register, against
// the ENTRIES-deep associative table, so the next transaction always sees the table
// as the previous one left it. Empty entries never match; new entries go round-robin,
// the first after reset into entry 1. Counters stop at their maximum value.
`default_nettype none

module branch_target_buffer_one_bit #(
    parameter int unsigned ENTRIES    = 32,
    parameter int unsigned ADDR_WIDTH = 32
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    // configuration
    input  wire                           i_cfg_we,
    input  wire  [btb1_pkg::DIST_W-1:0]   i_cfg_wdata,
    // input channel
    input  wire                           i_in_valid,
    output logic                          o_in_stall,
    input  wire  [ADDR_WIDTH-1:0]         i_pc,
    input  wire  [ADDR_WIDTH-1:0]         i_next_pc,
    // result channel
    output logic                          o_out_valid,
    input  wire                           i_out_stall,
    output logic                          o_table_hit,
    output logic                          o_predicted_taken,
    output logic                          o_actual_taken,
    output logic                          o_prediction_right,
    output logic                          o_entry_inserted,
    output logic [btb1_pkg::COUNT_W-1:0]  o_right_count,
    output logic [btb1_pkg::COUNT_W-1:0]  o_wrong_count,
    output logic [btb1_pkg::COUNT_W-1:0]  o_miss_count
);

    localparam int unsigned PTR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned CMP_W = (ADDR_WIDTH > btb1_pkg::DIST_W) ?
                                    ADDR_WIDTH : btb1_pkg::DIST_W;
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(ENTRIES - 1);

    // Configuration register
    btb1_pkg::t_dist r_taken_distance;

    // Input register
    logic                  r_in_valid;
    logic [ADDR_WIDTH-1:0] r_pc;
    logic [ADDR_WIDTH-1:0] r_next_pc;

    // Table
    logic [ADDR_WIDTH-1:0] r_entry_addr [ENTRIES];
    logic [ENTRIES-1:0]    r_entry_valid;
    logic [ENTRIES-1:0]    r_entry_pred;
    logic [PTR_W-1:0]      r_fill_ptr;

    // Counters
    btb1_pkg::t_count r_right_total;
    btb1_pkg::t_count r_wrong_total;
    btb1_pkg::t_count r_miss_total;

    // Result register
    logic r_out_valid;
    logic r_table_hit;
    logic r_pred_taken;
    logic r_actual_taken;
    logic r_pred_right;
    logic r_inserted;

    // Combinational
    logic                  s_out_free;
    logic                  s_proc;
    logic [ADDR_WIDTH:0]   s_diff;
    logic                  s_taken;
    logic [ENTRIES-1:0]    s_match;
    logic                  s_hit;
    logic [PTR_W-1:0]      s_slot;
    logic                  s_pred;
    logic                  s_right;
    logic                  s_insert;
    logic [PTR_W-1:0]      n_fill_ptr;

    // Handshake: the result register frees up when empty or taken this cycle
    assign s_out_free = !r_out_valid || !i_out_stall;
    assign s_proc     = r_in_valid && s_out_free;
    assign o_in_stall = r_in_valid && !s_out_free;

    // Outcome: borrow means backward step, else compare the forward distance
    assign s_diff  = {1'b0, r_next_pc} - {1'b0, r_pc};
    assign s_taken = s_diff[ADDR_WIDTH] ||
                     (CMP_W'(s_diff[ADDR_WIDTH-1:0]) > CMP_W'(r_taken_distance));

    // Associative match, one comparator per entry
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            s_match[i] = r_entry_valid[i] && (r_entry_addr[i] == r_pc);
        end
    end

    // Lowest matching entry wins
    always_comb begin
        s_slot = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (s_match[i]) begin
                s_slot = PTR_W'(i);
            end
        end
    end

    assign s_hit      = |s_match;
    assign s_pred     = s_hit && r_entry_pred[s_slot];
    assign s_right    = s_hit && (s_pred == s_taken);
    assign s_insert   = !s_hit && s_taken;
    assign n_fill_ptr = (r_fill_ptr >= LAST_SLOT) ? '0 : r_fill_ptr + PTR_W'(1);

    // Configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taken_distance <= btb1_pkg::DIST_RESET;
        end else if (i_cfg_we) begin
            r_taken_distance <= i_cfg_wdata;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!r_in_valid || s_out_free) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_pc      <= i_pc;
            r_next_pc <= i_next_pc;
        end
    end

    // Table control state: valid, prediction bits, fill pointer
    // On a hit the new prediction bit is always the outcome (flip on wrong, set on taken)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_valid <= '0;
            r_entry_pred  <= '0;
            r_fill_ptr    <= '0;
        end else if (s_proc) begin
            if (s_hit) begin
                r_entry_pred[s_slot] <= s_taken;
            end else if (s_insert) begin
                r_entry_valid[n_fill_ptr] <= 1'b1;
                r_entry_pred[n_fill_ptr]  <= 1'b1;
                r_fill_ptr                <= n_fill_ptr;
            end
        end
    end

    // Entry addresses, no reset: guarded by the valid bits
    always_ff @(posedge i_clk) begin
        if (s_proc && s_insert) begin
            r_entry_addr[n_fill_ptr] <= r_pc;
        end
    end

    // Saturating statistics
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_right_total <= '0;
            r_wrong_total <= '0;
            r_miss_total  <= '0;
        end else if (s_proc) begin
            if (s_right && (r_right_total != btb1_pkg::COUNT_MAX)) begin
                r_right_total <= r_right_total + btb1_pkg::COUNT_W'(1);
            end
            if (s_hit && !s_right && (r_wrong_total != btb1_pkg::COUNT_MAX)) begin
                r_wrong_total <= r_wrong_total + btb1_pkg::COUNT_W'(1);
            end
            if (s_insert && (r_miss_total != btb1_pkg::COUNT_MAX)) begin
                r_miss_total <= r_miss_total + btb1_pkg::COUNT_W'(1);
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_proc) begin
            r_table_hit    <= s_hit;
            r_pred_taken   <= s_pred;
            r_actual_taken <= s_taken;
            r_pred_right   <= s_right;
            r_inserted     <= s_insert;
        end
    end

    // Counters change only with a new result, so they drive the ports directly
    assign o_out_valid        = r_out_valid;
    assign o_table_hit        = r_table_hit;
    assign o_predicted_taken  = r_pred_taken;
    assign o_actual_taken     = r_actual_taken;
    assign o_prediction_right = r_pred_right;
    assign o_entry_inserted   = r_inserted;
    assign o_right_count      = r_right_total;
    assign o_wrong_count      = r_wrong_total;
    assign o_miss_count       = r_miss_total;

    // Checks
    a_hit_or_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_proc |-> !(s_hit && s_insert))
        else $error("hit and insertion in one transaction");

    a_right_needs_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_prediction_right |-> o_table_hit &&
                                              (o_predicted_taken == o_actual_taken))
        else $error("right prediction without a matching hit");

    a_ptr_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_proc && s_insert |=> r_fill_ptr != $past(r_fill_ptr))
        else $error("fill pointer did not advance on insertion");

    a_idle_stats: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_proc |=> $stable(r_right_total) && $stable(r_wrong_total) &&
                    $stable(r_miss_total) && $stable(r_fill_ptr))
        else $error("statistics changed without a transaction");

endmodule

`default_nettype wire
